>>> hdl/lzwd_pkg.sv
// lzwd_pkg: shared types and constants for the lzss window decoder
// no dependencies; used by lzwd_ctrl, lzwd_dp and lzss_window_decoder
package lzwd_pkg;

	localparam int unsigned REF_OFFSET     = 18;
	localparam int unsigned MIN_MATCH      = 3;
	localparam int unsigned FLAGS_PER_BYTE = 8;
	localparam int unsigned CNT_W          = 5;  // copy length up to 18
	localparam int unsigned FLAG_CNT_W     = 4;

	localparam logic ACT_BYTE    = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_COPY
	} lzwd_state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic restart;
		logic load_flags;
		logic put_literal;
		logic store_low;
		logic start_copy;
		logic copy_emit;
	} lzwd_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic out_free;
		logic flags_empty;
		logic flag_lit;
		logic expect_second;
		logic cnt_last;
	} lzwd_sts_t;

endpackage

>>> hdl/lzss_window_decoder.sv
// lzss_window_decoder: top level of the lzss stream decoder with a ring window
// depends on lzwd_pkg, lzwd_ctrl and lzwd_dp
//
//  channel | signals                        | moves
//  --------+--------------------------------+------------------------------------
//  in      | in_valid, in_ready, action,    | one compressed byte or a restart
//          | in_byte                        | request per accepted request
//  out     | out_valid, out_ready, out_byte,| one decoded byte; last_of_run marks
//          | last_of_run                    | the final byte of an input request
//
// flag bytes, first reference bytes and restarts emit nothing
// a literal loads the output register directly
// a reference emits length+3 bytes: it first starts the window read, then
// sends one byte per cycle from the single read port of the window memory
// a stall on out holds the copy in place; in_ready is low while a copy runs or
// the output register holds an untaken byte
// reset clears pointers, fill count and flag state; the window is not cleared,
// slots beyond the fill count read as zero
module lzss_window_decoder #(
	parameter int unsigned WINDOW_SIZE = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_of_run
);
	import lzwd_pkg::*;

	// command and status between the sequencer and the datapath
	lzwd_cmd_t cmd;
	lzwd_sts_t sts;

	// decode of each request and stepping through a back reference
	lzwd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.sts      (sts),
		.cmd      (cmd)
	);

	// ring window, stream state and the output register
	lzwd_dp #(
		.WINDOW_SIZE (WINDOW_SIZE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

>>> hdl/lzwd_ctrl.sv
// lzwd_ctrl: request decode and copy sequencing state machine
// depends on lzwd_pkg
module lzwd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  lzwd_pkg::lzwd_sts_t sts,
	output lzwd_pkg::lzwd_cmd_t cmd
);
	import lzwd_pkg::*;

	lzwd_state_t state_q;
	lzwd_state_t state_nx;
	logic        acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign in_ready = (state_q == ST_IDLE) && sts.out_free;
	assign acc      = in_valid && in_ready;

	// outputs
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (action == ACT_RESTART) begin
						cmd.restart = 1'b1;
					end else if (sts.flags_empty) begin
						cmd.load_flags = 1'b1;
					end else if (sts.flag_lit) begin
						cmd.put_literal = 1'b1;
					end else if (!sts.expect_second) begin
						cmd.store_low = 1'b1;
					end else begin
						cmd.start_copy = 1'b1;
					end
				end
			end
			ST_COPY: begin
				cmd.copy_emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && action == ACT_BYTE && !sts.flags_empty && !sts.flag_lit
						&& sts.expect_second) begin
					state_nx = ST_COPY;
				end
			end
			ST_COPY: begin
				if (sts.out_free && sts.cnt_last) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/lzwd_dp.sv
// lzwd_dp: window memory, stream state, copy pointers and output register
// depends on lzwd_pkg
module lzwd_dp #(
	parameter int unsigned WINDOW_SIZE = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lzwd_pkg::lzwd_cmd_t cmd,
	output lzwd_pkg::lzwd_sts_t sts,
	input  logic [7:0]         in_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               last_of_run
);
	import lzwd_pkg::*;

	localparam int unsigned AW = $clog2(WINDOW_SIZE);
	localparam int unsigned FW = AW + 1;

	logic [7:0]            mem [WINDOW_SIZE];
	logic [AW-1:0]         wp_q;
	logic [FW-1:0]         fill_q;
	logic [7:0]            flag_bits_q;
	logic [FLAG_CNT_W-1:0] flags_left_q;
	logic [7:0]            pair_low_q;
	logic                  expect_q;
	logic [AW-1:0]         src_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [7:0]            rd_q;
	logic [7:0]            wd_q;
	logic                  byp_q;
	logic                  zero_q;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  last_q;

	logic                  we;
	logic [7:0]            wd;
	logic [7:0]            copy_data;
	logic                  rd_en;
	logic [AW-1:0]         ra;
	logic [FW-1:0]         fill_after;
	logic                  next_flag;
	logic                  copy_fin;

	assign copy_data = zero_q ? 8'h00 : (byp_q ? wd_q : rd_q);
	assign copy_fin  = cmd.copy_emit && (cnt_q == CNT_W'(1));
	assign we        = cmd.put_literal || cmd.copy_emit;
	assign wd        = cmd.put_literal ? in_byte : copy_data;
	assign next_flag = cmd.put_literal || copy_fin;
	assign rd_en     = cmd.start_copy || (cmd.copy_emit && !copy_fin);
	assign ra        = cmd.start_copy
		? AW'({in_byte[7:4], pair_low_q}) + AW'(REF_OFFSET)
		: src_q + AW'(1);
	assign fill_after = (we && !fill_q[AW]) ? fill_q + FW'(1) : fill_q;

	assign sts.out_free      = !out_valid_q || out_ready;
	assign sts.flags_empty   = (flags_left_q == '0);
	assign sts.flag_lit      = flag_bits_q[0];
	assign sts.expect_second = expect_q;
	assign sts.cnt_last      = (cnt_q == CNT_W'(1));

	// window memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wp_q] <= wd;
		end
		if (rd_en) begin
			rd_q   <= mem[ra];
			wd_q   <= wd;
			byp_q  <= we && (wp_q == ra);
			zero_q <= !fill_after[AW] && ({1'b0, ra} >= fill_after);
			src_q  <= ra;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q         <= '0;
			fill_q       <= '0;
			flag_bits_q  <= '0;
			flags_left_q <= '0;
			pair_low_q   <= '0;
			expect_q     <= 1'b0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.restart) begin
				wp_q         <= '0;
				fill_q       <= '0;
				flag_bits_q  <= '0;
				flags_left_q <= '0;
				pair_low_q   <= '0;
				expect_q     <= 1'b0;
			end else begin
				if (we) begin
					wp_q   <= wp_q + AW'(1);
					fill_q <= fill_after;
				end
				if (cmd.load_flags) begin
					flag_bits_q  <= in_byte;
					flags_left_q <= FLAG_CNT_W'(FLAGS_PER_BYTE);
				end else if (next_flag) begin
					flag_bits_q  <= flag_bits_q >> 1;
					flags_left_q <= flags_left_q - FLAG_CNT_W'(1);
				end
				if (cmd.store_low) begin
					pair_low_q <= in_byte;
					expect_q   <= 1'b1;
				end else if (copy_fin) begin
					expect_q <= 1'b0;
				end
			end
			if (cmd.start_copy) begin
				cnt_q <= CNT_W'(in_byte[3:0]) + CNT_W'(MIN_MATCH);
			end else if (cmd.copy_emit) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (we) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			out_byte_q <= wd;
			last_q     <= cmd.put_literal || copy_fin;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

endmodule

>>> sim/tb_top.sv
// tb_top: self-checking testbench for the lzss window decoder
// holds a byte-accurate decode predictor, random stimulus and a result checker
// depends on lzwd_pkg and lzss_window_decoder from the hdl folder
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lzwd_pkg::*;

	localparam int WIN        = 4096;
	localparam int IDLE_LIMIT = 3000;  // cycles with no request moving on either side

	// one decoded byte as it should leave the block
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_rec_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       action = ACT_BYTE;
	logic [7:0] in_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       last_of_run;

	// mirror of the decoder state
	logic [7:0]  ring [WIN];
	logic [11:0] ring_wr;
	logic [12:0] ring_fill;
	logic [7:0]  flag_reg;
	logic [3:0]  flag_cnt;
	logic [7:0]  low_byte;
	logic        want_high;
	// physical slots written since power-up always form a prefix [0, phys_hw)
	int          phys_hw;

	out_rec_t pending_out [$];
	out_rec_t got_rec;
	int       errors = 0;
	int       idle_cycles = 0;

	// stimulus knobs
	bit         quiet = 1'b0;
	int         gap_pct = 25;
	int         stall_pct = 25;
	int         stall_left = 0;
	int         lit_pct = 50;
	int         long_pct = 20;
	int         restart_permil = 0;
	logic [7:0] ref_high;

	lzss_window_decoder DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last_of_run(last_of_run)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [7:0] read_ring(input logic [11:0] s);
		// slots past the fill count since the last restart read as zero
		if (ring_fill < 13'(WIN) && {1'b0, s} >= ring_fill) return 8'h00;
		return ring[s];
	endfunction

	task automatic emit(input logic [7:0] v, input logic last);
		out_rec_t r;
		ring[ring_wr] = v;
		ring_wr = ring_wr + 1'b1;
		if (ring_fill < 13'(WIN)) ring_fill = ring_fill + 1'b1;
		if (int'(ring_fill) > phys_hw) phys_hw = int'(ring_fill);
		r.data = v;
		r.last = last;
		pending_out.push_back(r);
	endtask

	task automatic clear_stream();
		ring_wr = '0;
		ring_fill = '0;
		flag_reg = '0;
		flag_cnt = '0;
		low_byte = '0;
		want_high = 1'b0;
	endtask

	task automatic step_flag();
		flag_reg = flag_reg >> 1;
		if (flag_cnt != 0) flag_cnt = flag_cnt - 1'b1;
	endtask

	// work out every byte one accepted request should produce
	task automatic decode_byte(input logic act, input logic [7:0] b);
		logic [11:0] src;
		int          len;
		if (act == ACT_RESTART) begin
			clear_stream();
		end else if (flag_cnt == 0) begin
			flag_reg = b;
			flag_cnt = 4'(FLAGS_PER_BYTE);
		end else if (flag_reg[0]) begin
			emit(b, 1'b1);
			step_flag();
		end else if (!want_high) begin
			low_byte = b;
			want_high = 1'b1;
		end else begin
			// copy byte by byte so an overlapping source sees fresh data
			src = {b[7:4], low_byte} + 12'(REF_OFFSET);
			len = int'(b[3:0]) + MIN_MATCH;
			for (int i = 0; i < len; i++) begin
				emit(read_ring(src), i == len - 1);
				src = src + 1'b1;
			end
			want_high = 1'b0;
			step_flag();
		end
	endtask

	// true when every slot the copy touches was physically written before,
	// either earlier in the run or earlier in this same copy
	function automatic bit ref_safe(input logic [11:0] src, input int len);
		int h;
		int w;
		int s;
		h = phys_hw;
		w = int'(ring_wr);
		for (int i = 0; i < len; i++) begin
			s = (int'(src) + i) % WIN;
			if (s >= h) return 1'b0;
			if (h < WIN && w + 1 > h) h = w + 1;
			w = (w + 1) % WIN;
		end
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- drivers

	// one request on the input side; valid stays up for back-to-back requests
	task automatic send_item(input logic act, input logic [7:0] b);
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		in_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		decode_byte(act, b);
	endtask

	// hold the sender until every predicted byte has come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_out.size() != 0);
	endtask

	task automatic send_ref(input logic [11:0] src, input int len);
		logic [11:0] pos;
		pos = src - 12'(REF_OFFSET);
		send_item(ACT_BYTE, pos[7:0]);
		send_item(ACT_BYTE, {pos[11:8], 4'(len - MIN_MATCH)});
	endtask

	// next request of a well-formed stream with random content; restarts are the noise
	task automatic send_stream_item();
		logic [7:0]  b;
		logic [11:0] src;
		logic [11:0] pos;
		int          len;
		bit          ok;
		if ($urandom_range(0, 999) < restart_permil) begin
			send_item(ACT_RESTART, 8'($urandom));
		end else if (flag_cnt == 0) begin
			for (int k = 0; k < 8; k++) b[k] = ($urandom_range(0, 99) < lit_pct);
			send_item(ACT_BYTE, b);
		end else if (flag_reg[0]) begin
			send_item(ACT_BYTE, 8'($urandom));
		end else if (want_high) begin
			send_item(ACT_BYTE, ref_high);
		end else begin
			ok = 1'b0;
			src = '0;
			len = MIN_MATCH;
			for (int k = 0; k < 16 && !ok; k++) begin
				len = ($urandom_range(0, 99) < long_pct) ? 18 : $urandom_range(3, 18);
				case ($urandom_range(0, 2))
					0: src = ring_wr - 12'($urandom_range(1, 24));
					1: src = 12'($urandom_range(0, phys_hw > 0 ? phys_hw - 1 : 0));
					default: src = 12'($urandom);
				endcase
				ok = ref_safe(src, len);
			end
			if (!ok) begin
				// nothing readable yet, break the stream instead
				send_item(ACT_RESTART, 8'($urandom));
			end else begin
				pos = src - 12'(REF_OFFSET);
				ref_high = {pos[11:8], 4'(len - MIN_MATCH)};
				send_item(ACT_BYTE, pos[7:0]);
			end
		end
	endtask

	// receiver: random stall bursts, none in quiet mode
	initial begin
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(1, 18) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- checker

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_out.size() == 0) begin
				errors++;
				$display("%0t: unexpected byte, expected none, actual %02h last %0b",
					$time, out_byte, last_of_run);
			end else begin
				got_rec = pending_out.pop_front();
				if (out_byte !== got_rec.data) begin
					errors++;
					$display("%0t: out_byte mismatch, expected %02h, actual %02h",
						$time, got_rec.data, out_byte);
				end
				if (last_of_run !== got_rec.last) begin
					errors++;
					$display("%0t: last_of_run mismatch, expected %0b, actual %0b",
						$time, got_rec.last, last_of_run);
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
	end

	// watchdog on cycles where no request moves
	initial begin
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// ---------------------------------------------------------------- tests

	// extremes of every byte kind, overlap copy, restart mid reference,
	// and reads of slots that are stale since the last restart
	task automatic test_directed();
		send_item(ACT_BYTE, 8'hFF);
		send_item(ACT_BYTE, 8'h00);
		send_item(ACT_BYTE, 8'hFF);
		send_item(ACT_BYTE, 8'hA5);
		send_item(ACT_BYTE, 8'h5A);
		send_item(ACT_BYTE, 8'h01);
		send_item(ACT_BYTE, 8'h80);
		send_item(ACT_BYTE, 8'h3C);
		send_item(ACT_BYTE, 8'hC3);
		send_item(ACT_BYTE, 8'h00);
		send_ref(12'd0, 18);   // position 0xfee, longest copy, overlaps its own output
		send_ref(12'd17, 3);   // position 0xfff, shortest copy
		send_ref(12'd18, 3);   // position 0x000
		send_item(ACT_BYTE, 8'h12);
		send_item(ACT_RESTART, 8'hFF);  // drop the half reference
		send_item(ACT_BYTE, 8'h00);
		send_ref(12'd0, 8);    // copy at stream start reads zeros
		send_ref(12'd20, 3);   // old data past the fill count reads zero
		send_item(ACT_RESTART, 8'h00);
		wait_idle();
	endtask

	// one long stream so the ring wraps and the fill count saturates;
	// mostly longest copies so the window fills with few requests
	task automatic test_full_window();
		restart_permil = 0;
		lit_pct = 5;
		long_pct = 100;
		send_item(ACT_RESTART, 8'h00);
		while (ring_fill < 13'(WIN)) send_stream_item();
		lit_pct = 40;
		long_pct = 30;
		repeat (16) send_stream_item();
		wait_idle();
	endtask

	// mixed streams, knobs change every block of 16 requests
	task automatic test_random();
		int pick;
		for (int n = 0; n < 32; n++) begin
			if (n % 16 == 0) begin
				lit_pct = $urandom_range(0, 100);
				long_pct = $urandom_range(0, 60);
				pick = $urandom_range(0, 2);
				restart_permil = (pick == 0) ? 0 : (pick == 1) ? 15 : 60;
				pick = $urandom_range(0, 2);
				gap_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 40;
				pick = $urandom_range(0, 2);
				stall_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 40;
			end
			if ($urandom_range(0, 99) == 0) wait_idle();
			send_stream_item();
		end
	endtask

	// full rate on both sides to close the run
	task automatic test_quiet();
		quiet = 1'b1;
		restart_permil = 5;
		lit_pct = 50;
		long_pct = 20;
		repeat (16) send_stream_item();
	endtask

	initial begin
		clear_stream();
		phys_hw = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_window();
		test_random();
		test_quiet();
		wait_idle();
		repeat (40) @(posedge clk);
		if (pending_out.size() != 0) begin
			errors++;
			$display("%0t: %0d bytes expected, actual none", $time, pending_out.size());
		end
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
